### sv/imdu_pkg.sv
package imdu_pkg;

    localparam int XLEN      = 64;
    localparam int NUM_CELLS = XLEN;
    localparam int TAG_W     = 5;
    localparam int MODE_W    = 4;
    localparam int IN_W      = 144;
    localparam int OUT_W     = 72;

    localparam logic [MODE_W-1:0] MODE_MUL    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_MULH   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MULHSU = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MULHU  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIV    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DIVU   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_REM    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_REMU   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_MULW   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_DIVW   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_DIVUW  = 4'd10;
    localparam logic [MODE_W-1:0] MODE_REMW   = 4'd11;
    localparam logic [MODE_W-1:0] MODE_REMUW  = 4'd12;

    // result selection carried alongside each request
    localparam logic [2:0] SEL_ZERO = 3'd0;
    localparam logic [2:0] SEL_LO   = 3'd1;
    localparam logic [2:0] SEL_HI   = 3'd2;
    localparam logic [2:0] SEL_QUO  = 3'd3;
    localparam logic [2:0] SEL_REM  = 3'd4;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [2:0]       sel;
        logic             w;
        logic             neg;
        logic [XLEN-1:0]  corr;
    } t_side;

    typedef struct packed {
        logic            valid;
        logic            is_div;
        logic [XLEN-1:0] hi;
        logic [XLEN-1:0] x;
        logic [XLEN-1:0] y;
        t_side           side;
    } t_cell;

endpackage

### sv/integer_multiply_divide_unit_core.sv
// RV64M multiply/divide unit. Takes one request per cycle and returns one result per request,
// in order, after it has passed one decode stage, a chain of 64 identical cells that each
// retire one bit of the product or quotient, and one output stage that applies the sign and
// word-form fix-ups. The whole chain stalls while a result waits at the output, so
// throughput is one request per cycle whenever the consumer keeps m_axis_tready high.
module integer_multiply_divide_unit_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // mode[3:0], operand_a[67:4], operand_b[131:68], dest_reg[136:132], zero pad
    input  logic [imdu_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // result_tag[4:0], result_value[68:5], zero pad
    output logic [imdu_pkg::OUT_W-1:0]   m_axis_tdata
);
    import imdu_pkg::*;

    logic             en;
    t_cell            chain [0:NUM_CELLS];
    logic [TAG_W-1:0] res_tag;
    logic [XLEN-1:0]  res_value;

    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    imdu_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tdata[3:0]),
        .i_a     (s_axis_tdata[67:4]),
        .i_b     (s_axis_tdata[131:68]),
        .i_tag   (s_axis_tdata[136:132]),
        .o_cell  (chain[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        imdu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (chain[k]),
            .o_cell  (chain[k+1])
        );
    end

    imdu_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cell  (chain[NUM_CELLS]),
        .o_valid (m_axis_tvalid),
        .o_tag   (res_tag),
        .o_value (res_value)
    );

    assign m_axis_tdata = {{(OUT_W - XLEN - TAG_W){1'b0}}, res_value, res_tag};

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> chain[0].valid)
        else $error("accepted request missing from decode stage");

    a_chain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(chain[NUM_CELLS]))
        else $error("last cell moved during stall");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && chain[NUM_CELLS].valid) |=> m_axis_tvalid)
        else $error("finished request lost at output stage");

endmodule

### sv/imdu_prep.sv
module imdu_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [imdu_pkg::MODE_W-1:0]  i_mode,
    input  logic [imdu_pkg::XLEN-1:0]    i_a,
    input  logic [imdu_pkg::XLEN-1:0]    i_b,
    input  logic [imdu_pkg::TAG_W-1:0]   i_tag,
    output imdu_pkg::t_cell              o_cell
);
    import imdu_pkg::*;

    t_cell           r_cell;
    t_cell           n_cell;
    logic [XLEN-1:0] a32, b32, sa32, sb32, da, db;
    logic            w, sgn, want_rem, na, nb;

    always_comb begin
        a32  = {32'd0, i_a[31:0]};
        b32  = {32'd0, i_b[31:0]};
        sa32 = {{32{i_a[31]}}, i_a[31:0]};
        sb32 = {{32{i_b[31]}}, i_b[31:0]};
        w        = (i_mode inside {[MODE_MULW:MODE_REMUW]});
        sgn      = (i_mode inside {MODE_DIV, MODE_REM, MODE_DIVW, MODE_REMW});
        want_rem = (i_mode inside {MODE_REM, MODE_REMU, MODE_REMW, MODE_REMUW});
        da = w ? (sgn ? sa32 : a32) : i_a;
        db = w ? (sgn ? sb32 : b32) : i_b;
        na = sgn & da[XLEN-1];
        nb = sgn & db[XLEN-1];

        n_cell           = '0;
        n_cell.valid     = i_valid;
        n_cell.side.tag  = i_tag;
        n_cell.side.w    = w;
        case (i_mode)
            MODE_MUL, MODE_MULHU: begin
                n_cell.x        = i_a;
                n_cell.y        = i_b;
                n_cell.side.sel = (i_mode == MODE_MUL) ? SEL_LO : SEL_HI;
            end
            MODE_MULH: begin
                n_cell.x         = i_a;
                n_cell.y         = i_b;
                n_cell.side.sel  = SEL_HI;
                n_cell.side.corr = (i_a[XLEN-1] ? i_b : '0) + (i_b[XLEN-1] ? i_a : '0);
            end
            MODE_MULHSU: begin
                n_cell.x         = i_a;
                n_cell.y         = i_b;
                n_cell.side.sel  = SEL_HI;
                n_cell.side.corr = i_a[XLEN-1] ? i_b : '0;
            end
            MODE_MULW: begin
                n_cell.x        = a32;
                n_cell.y        = b32;
                n_cell.side.sel = SEL_LO;
            end
            MODE_DIV, MODE_DIVU, MODE_REM, MODE_REMU,
            MODE_DIVW, MODE_DIVUW, MODE_REMW, MODE_REMUW: begin
                n_cell.is_div   = 1'b1;
                n_cell.x        = na ? (XLEN'(0) - da) : da;
                n_cell.y        = nb ? (XLEN'(0) - db) : db;
                n_cell.side.sel = want_rem ? SEL_REM : SEL_QUO;
                // a zero divisor keeps the all-ones quotient unsigned
                n_cell.side.neg = want_rem ? na : ((na ^ nb) & (db != '0));
            end
            default: n_cell.side.sel = SEL_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.is_div <= n_cell.is_div;
            r_cell.hi     <= n_cell.hi;
            r_cell.x      <= n_cell.x;
            r_cell.y      <= n_cell.y;
            r_cell.side   <= n_cell.side;
        end
    end

    assign o_cell = r_cell;

endmodule

### sv/imdu_cell.sv
module imdu_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  imdu_pkg::t_cell i_cell,
    output imdu_pkg::t_cell o_cell
);
    import imdu_pkg::*;

    t_cell         r_cell;
    t_cell         n_cell;
    logic [XLEN:0]   rem_w;
    logic [XLEN+1:0] diff;
    logic [XLEN:0]   sum;

    always_comb begin
        n_cell = i_cell;
        rem_w  = {i_cell.hi, i_cell.x[XLEN-1]};
        diff   = {1'b0, rem_w} - {2'b00, i_cell.y};
        sum    = {1'b0, i_cell.hi} + (i_cell.x[0] ? {1'b0, i_cell.y} : '0);
        if (i_cell.is_div) begin
            // one restoring step, quotient bit enters at the bottom
            n_cell.hi = diff[XLEN+1] ? rem_w[XLEN-1:0] : diff[XLEN-1:0];
            n_cell.x  = {i_cell.x[XLEN-2:0], ~diff[XLEN+1]};
        end else begin
            // one shift-add step, product low half fills x from the top
            n_cell.hi = sum[XLEN:1];
            n_cell.x  = {sum[0], i_cell.x[XLEN-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.is_div <= n_cell.is_div;
            r_cell.hi     <= n_cell.hi;
            r_cell.x      <= n_cell.x;
            r_cell.y      <= n_cell.y;
            r_cell.side   <= n_cell.side;
        end
    end

    assign o_cell = r_cell;

endmodule

### sv/imdu_post.sv
module imdu_post (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  imdu_pkg::t_cell             i_cell,
    output logic                        o_valid,
    output logic [imdu_pkg::TAG_W-1:0]  o_tag,
    output logic [imdu_pkg::XLEN-1:0]   o_value
);
    import imdu_pkg::*;

    logic            r_valid;
    logic [TAG_W-1:0] r_tag;
    logic [XLEN-1:0] r_value;
    logic [XLEN-1:0] base, p, m, v, n_value;

    always_comb begin
        base = (i_cell.side.sel == SEL_REM) ? i_cell.hi : i_cell.x;
        case (i_cell.side.sel)
            SEL_HI: begin
                p = i_cell.hi;
                m = i_cell.side.corr;
            end
            SEL_LO, SEL_QUO, SEL_REM: begin
                p = i_cell.side.neg ? '0 : base;
                m = i_cell.side.neg ? base : '0;
            end
            default: begin
                p = '0;
                m = '0;
            end
        endcase
        v       = p - m;
        n_value = i_cell.side.w ? {{32{v[31]}}, v[31:0]} : v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cell.valid;
        end
        if (i_en) begin
            r_tag   <= i_cell.side.tag;
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_value = r_value;

endmodule
